// File: src/ccri_pkg.sv
// Shared types and constants for the cylinder cap ray intersection block.
// Holds field widths, register codes and the pipeline record types.
// No dependencies.
package ccri_pkg;

	localparam int POS_W   = 32;
	localparam int DIR_W   = 18;
	localparam int T_W     = 31;
	localparam int TDATA_W = 184;
	localparam int ADDR_W  = 5;
	localparam int AD_W    = 36;
	localparam int NUM_W   = 55;
	localparam int AN_W    = 54;
	localparam int LO_W    = 15;

	typedef enum logic [2:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_AXIS_X   = 3'd3,
		REG_AXIS_Y   = 3'd4,
		REG_AXIS_Z   = 3'd5,
		REG_DIAMETER = 3'd6,
		REG_HEIGHT   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [2:0][POS_W-1:0] o;
		logic [2:0][DIR_W-1:0] d;
		logic [T_W-1:0]        lim;
	} ray_t;

	// one lane of the restoring divider
	typedef struct packed {
		logic [AD_W-1:0] rem;
		logic [T_W-1:0]  q;
		logic [LO_W-1:0] lo;
		logic            ok;
	} div_t;

endpackage

// File: src/cylinder_cap_ray_intersect.sv
// Ray test against both end disks of a configured cylinder, Q16.16 fixed point.
// One item per cycle sustained while the output item is taken.
// Most of the pipeline is the two 31-stage restoring dividers (one quotient bit per stage).
// The whole pipeline advances together; it holds when the output item is not taken.
// arst_n clears all valid bits and loads the register reset values; no clearing pass.
// Depends on ccri_pkg.
module cylinder_cap_ray_intersect (
	input  logic                          clk,
	input  logic                          arst_n,
	// s_axis_tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_limit, zero pad
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [ccri_pkg::TDATA_W-1:0]  s_axis_tdata,
	// m_axis_tdata: t_out, point_x, point_y, point_z, normal_x, normal_y, normal_z, zero pad
	// m_axis_tuser: hit
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [ccri_pkg::TDATA_W-1:0]  m_axis_tdata,
	output logic                          m_axis_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ccri_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import ccri_pkg::*;

	localparam int DN = T_W + 1;

	// configuration
	logic signed [POS_W-1:0] cen_q  [3];
	logic signed [DIR_W-1:0] axis_q [3];
	logic [T_W-1:0]          dia_q;
	logic [T_W-1:0]          hgt_q;
	logic signed [33:0]      tc_q   [3];
	logic [61:0]             dsq_q;
	logic signed [49:0]      ah_c   [3];
	logic                    wr;
	reg_idx_t                ridx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign ridx   = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cen_q[0]  <= '0;
			cen_q[1]  <= '0;
			cen_q[2]  <= '0;
			axis_q[0] <= '0;
			axis_q[1] <= 18'sd65536;
			axis_q[2] <= '0;
			dia_q     <= 31'd65536;
			hgt_q     <= 31'd65536;
		end else if (wr) begin
			case (ridx)
				REG_CENTER_X: cen_q[0]  <= pwdata;
				REG_CENTER_Y: cen_q[1]  <= pwdata;
				REG_CENTER_Z: cen_q[2]  <= pwdata;
				REG_AXIS_X:   axis_q[0] <= pwdata[DIR_W-1:0];
				REG_AXIS_Y:   axis_q[1] <= pwdata[DIR_W-1:0];
				REG_AXIS_Z:   axis_q[2] <= pwdata[DIR_W-1:0];
				REG_DIAMETER: dia_q     <= pwdata[T_W-1:0];
				REG_HEIGHT:   hgt_q     <= pwdata[T_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_CENTER_X: prdata = cen_q[0];
			REG_CENTER_Y: prdata = cen_q[1];
			REG_CENTER_Z: prdata = cen_q[2];
			REG_AXIS_X:   prdata = 32'(axis_q[0]);
			REG_AXIS_Y:   prdata = 32'(axis_q[1]);
			REG_AXIS_Z:   prdata = 32'(axis_q[2]);
			REG_DIAMETER: prdata = {1'b0, dia_q};
			REG_HEIGHT:   prdata = {1'b0, hgt_q};
			default:      prdata = '0;
		endcase
	end

	// top disk center and squared diameter, refreshed from the registers every cycle
	always_comb begin
		for (int i = 0; i < 3; i++)
			ah_c[i] = axis_q[i] * $signed({1'b0, hgt_q});
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			tc_q[i] <= 34'(cen_q[i]) + 34'($signed(ah_c[i][49:16]));
		dsq_q <= 62'(dia_q) * 62'(dia_q);
	end

	function automatic div_t div_step(input div_t x, input logic [AD_W-1:0] ad);
		logic [AD_W:0] r2;
		div_t          y;
		r2   = {x.rem, x.lo[LO_W-1]};
		y    = x;
		y.lo = {x.lo[LO_W-2:0], 1'b0};
		if (r2 >= {1'b0, ad}) begin
			y.rem = AD_W'(r2 - {1'b0, ad});
			y.q   = {x.q[T_W-2:0], 1'b1};
		end else begin
			y.rem = r2[AD_W-1:0];
			y.q   = {x.q[T_W-2:0], 1'b0};
		end
		return y;
	endfunction

	function automatic logic [POS_W-1:0] sat_pos(input logic signed [34:0] x);
		if (x > 35'sd2147483647)
			return 32'h7FFF_FFFF;
		else if (x < -35'sd2147483648)
			return 32'h8000_0000;
		else
			return x[POS_W-1:0];
	endfunction

	// pipeline
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, out_v_q;
	logic v_sd [DN];

	ray_t ray_in, ray_s1, ray_s2, ray_s3, ray_s4, ray_s5;
	ray_t ray_s6, ray_s7, ray_s8, ray_s9, ray_s10, ray_s11;
	ray_t ray_sd [DN];

	logic signed [35:0] pd_s2 [3];
	logic signed [32:0] db_s2 [3];
	logic signed [34:0] dt_s2 [3];
	logic signed [36:0] den_s3, den_s4;
	logic signed [50:0] nb_s3 [3];
	logic signed [52:0] nt_s3 [3];
	logic signed [NUM_W-1:0] numb_s4, numt_s4;
	logic [AD_W-1:0] ad_s5;
	logic [AN_W-1:0] anb_s5, ant_s5;
	logic            okb_s5, okt_s5;
	logic [AD_W-1:0] ad_sd [DN];
	div_t            divb_sd [DN];
	div_t            divt_sd [DN];

	logic [T_W-1:0] tb_s6, tt_s6, tb_s7, tt_s7, tb_s8, tt_s8, tb_s9, tt_s9;
	logic [T_W-1:0] tb_s10, tt_s10, tb_s11, tt_s11;
	logic okb_s6, okt_s6, okb_s7, okt_s7, okb_s8, okt_s8, okb_s9, okt_s9;
	logic okb_s10, okt_s10, passb_s11, passt_s11;
	logic signed [49:0] mb_s6 [3];
	logic signed [49:0] mt_s6 [3];
	logic signed [34:0] ptb_s7 [3];
	logic signed [34:0] ptt_s7 [3];
	logic signed [35:0] dfb_s8 [3];
	logic signed [35:0] dft_s8 [3];
	logic [POS_W-1:0] psb_s8 [3];
	logic [POS_W-1:0] pst_s8 [3];
	logic [POS_W-1:0] psb_s9 [3];
	logic [POS_W-1:0] pst_s9 [3];
	logic [POS_W-1:0] psb_s10 [3];
	logic [POS_W-1:0] pst_s10 [3];
	logic [POS_W-1:0] psb_s11 [3];
	logic [POS_W-1:0] pst_s11 [3];
	logic [29:0] ab_s9 [3];
	logic [29:0] at_s9 [3];
	logic [59:0] sqb_s10 [3];
	logic [59:0] sqt_s10 [3];

	logic            out_hit_q;
	logic [T_W-1:0]  out_t_q;
	logic [POS_W-1:0] out_p_q [3];
	logic [DIR_W-1:0] out_n_q [3];

	// combinational stage logic
	logic signed [36:0]      den_c;
	logic signed [NUM_W-1:0] numb_c, numt_c;
	logic [AN_W-1:0]         anb_c, ant_c;
	div_t                    d0b_c, d0t_c;
	logic [AD_W-1:0]         ab_c [3];
	logic [AD_W-1:0]         at_c [3];
	logic                    inb_c, int_c;
	logic [61:0]             sumb_c, sumt_c;
	logic                    hb_c, ht_c;
	logic [T_W-1:0]          lim1_c;
	logic signed [DIR_W:0]   nneg_c [3];
	logic [DIR_W-1:0]        nbot_c [3];

	assign en            = !out_v_q || m_axis_tready;
	assign s_axis_tready = en;

	always_comb begin
		ray_in.o[0] = s_axis_tdata[31:0];
		ray_in.o[1] = s_axis_tdata[63:32];
		ray_in.o[2] = s_axis_tdata[95:64];
		ray_in.d[0] = s_axis_tdata[113:96];
		ray_in.d[1] = s_axis_tdata[131:114];
		ray_in.d[2] = s_axis_tdata[149:132];
		ray_in.lim  = s_axis_tdata[180:150];
	end

	always_comb begin
		den_c  = 37'(pd_s2[0]) + 37'(pd_s2[1]) + 37'(pd_s2[2]);
		numb_c = NUM_W'(nb_s3[0]) + NUM_W'(nb_s3[1]) + NUM_W'(nb_s3[2]);
		numt_c = NUM_W'(nt_s3[0]) + NUM_W'(nt_s3[1]) + NUM_W'(nt_s3[2]);
		anb_c  = AN_W'(numb_s4 < 0 ? -numb_s4 : numb_s4);
		ant_c  = AN_W'(numt_s4 < 0 ? -numt_s4 : numt_s4);

		// quotient must fit in 31 bits: an < ad * 2^15
		d0b_c.rem = anb_s5[AD_W+LO_W-1:LO_W];
		d0b_c.lo  = anb_s5[LO_W-1:0];
		d0b_c.q   = '0;
		d0b_c.ok  = okb_s5 && (anb_s5 < AN_W'({ad_s5, {LO_W{1'b0}}}));
		d0t_c.rem = ant_s5[AD_W+LO_W-1:LO_W];
		d0t_c.lo  = ant_s5[LO_W-1:0];
		d0t_c.q   = '0;
		d0t_c.ok  = okt_s5 && (ant_s5 < AN_W'({ad_s5, {LO_W{1'b0}}}));

		inb_c = 1'b1;
		int_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			ab_c[i] = AD_W'(dfb_s8[i] < 0 ? -dfb_s8[i] : dfb_s8[i]);
			at_c[i] = AD_W'(dft_s8[i] < 0 ? -dft_s8[i] : dft_s8[i]);
			if (ab_c[i] > AD_W'(dia_q[T_W-1:1]))
				inb_c = 1'b0;
			if (at_c[i] > AD_W'(dia_q[T_W-1:1]))
				int_c = 1'b0;
		end
		sumb_c = 62'(sqb_s10[0]) + 62'(sqb_s10[1]) + 62'(sqb_s10[2]);
		sumt_c = 62'(sqt_s10[0]) + 62'(sqt_s10[1]) + 62'(sqt_s10[2]);

		// bottom disk first, then top against the lowered limit
		hb_c   = passb_s11 && (tb_s11 < ray_s11.lim);
		lim1_c = hb_c ? tb_s11 : ray_s11.lim;
		ht_c   = passt_s11 && (tt_s11 < lim1_c);
		for (int i = 0; i < 3; i++) begin
			nneg_c[i] = -(19'(axis_q[i]));
			nbot_c[i] = (nneg_c[i] > 19'sd131071) ? 18'h1FFFF : nneg_c[i][DIR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			v_s8    <= 1'b0;
			v_s9    <= 1'b0;
			v_s10   <= 1'b0;
			v_s11   <= 1'b0;
			out_v_q <= 1'b0;
			for (int k = 0; k < DN; k++)
				v_sd[k] <= 1'b0;
		end else if (en) begin
			v_s1    <= s_axis_tvalid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_sd[0] <= v_s5;
			for (int k = 1; k < DN; k++)
				v_sd[k] <= v_sd[k-1];
			v_s6    <= v_sd[DN-1];
			v_s7    <= v_s6;
			v_s8    <= v_s7;
			v_s9    <= v_s8;
			v_s10   <= v_s9;
			v_s11   <= v_s10;
			out_v_q <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1 <= ray_in;

			ray_s2 <= ray_s1;
			for (int i = 0; i < 3; i++) begin
				pd_s2[i] <= axis_q[i] * $signed(ray_s1.d[i]);
				db_s2[i] <= 33'(cen_q[i]) - 33'($signed(ray_s1.o[i]));
				dt_s2[i] <= 35'(tc_q[i]) - 35'($signed(ray_s1.o[i]));
			end

			ray_s3 <= ray_s2;
			den_s3 <= den_c;
			for (int i = 0; i < 3; i++) begin
				nb_s3[i] <= db_s2[i] * axis_q[i];
				nt_s3[i] <= dt_s2[i] * axis_q[i];
			end

			ray_s4  <= ray_s3;
			den_s4  <= den_s3;
			numb_s4 <= numb_c;
			numt_s4 <= numt_c;

			// top disk: both num and den are negated, so the sign test is shared
			ray_s5 <= ray_s4;
			ad_s5  <= AD_W'(den_s4 < 0 ? -den_s4 : den_s4);
			anb_s5 <= anb_c;
			ant_s5 <= ant_c;
			okb_s5 <= (den_s4 != 0) && (numb_s4 != 0) && ((numb_s4 < 0) == (den_s4 < 0));
			okt_s5 <= (den_s4 != 0) && (numt_s4 != 0) && ((numt_s4 < 0) == (den_s4 < 0));

			ray_sd[0]  <= ray_s5;
			ad_sd[0]   <= ad_s5;
			divb_sd[0] <= d0b_c;
			divt_sd[0] <= d0t_c;
			for (int k = 1; k < DN; k++) begin
				ray_sd[k]  <= ray_sd[k-1];
				ad_sd[k]   <= ad_sd[k-1];
				divb_sd[k] <= div_step(divb_sd[k-1], ad_sd[k-1]);
				divt_sd[k] <= div_step(divt_sd[k-1], ad_sd[k-1]);
			end

			ray_s6 <= ray_sd[DN-1];
			tb_s6  <= divb_sd[DN-1].q;
			tt_s6  <= divt_sd[DN-1].q;
			okb_s6 <= divb_sd[DN-1].ok && (divb_sd[DN-1].q != '0);
			okt_s6 <= divt_sd[DN-1].ok && (divt_sd[DN-1].q != '0);
			for (int i = 0; i < 3; i++) begin
				mb_s6[i] <= $signed(ray_sd[DN-1].d[i]) * $signed({1'b0, divb_sd[DN-1].q});
				mt_s6[i] <= $signed(ray_sd[DN-1].d[i]) * $signed({1'b0, divt_sd[DN-1].q});
			end

			ray_s7 <= ray_s6;
			tb_s7  <= tb_s6;
			tt_s7  <= tt_s6;
			okb_s7 <= okb_s6;
			okt_s7 <= okt_s6;
			for (int i = 0; i < 3; i++) begin
				ptb_s7[i] <= 35'($signed(ray_s6.o[i])) + 35'($signed(mb_s6[i][49:16]));
				ptt_s7[i] <= 35'($signed(ray_s6.o[i])) + 35'($signed(mt_s6[i][49:16]));
			end

			ray_s8 <= ray_s7;
			tb_s8  <= tb_s7;
			tt_s8  <= tt_s7;
			okb_s8 <= okb_s7;
			okt_s8 <= okt_s7;
			for (int i = 0; i < 3; i++) begin
				dfb_s8[i] <= 36'(ptb_s7[i]) - 36'(cen_q[i]);
				dft_s8[i] <= 36'(ptt_s7[i]) - 36'(tc_q[i]);
				psb_s8[i] <= sat_pos(ptb_s7[i]);
				pst_s8[i] <= sat_pos(ptt_s7[i]);
			end

			ray_s9 <= ray_s8;
			tb_s9  <= tb_s8;
			tt_s9  <= tt_s8;
			okb_s9 <= okb_s8 && inb_c;
			okt_s9 <= okt_s8 && int_c;
			for (int i = 0; i < 3; i++) begin
				ab_s9[i]  <= ab_c[i][29:0];
				at_s9[i]  <= at_c[i][29:0];
				psb_s9[i] <= psb_s8[i];
				pst_s9[i] <= pst_s8[i];
			end

			ray_s10 <= ray_s9;
			tb_s10  <= tb_s9;
			tt_s10  <= tt_s9;
			okb_s10 <= okb_s9;
			okt_s10 <= okt_s9;
			for (int i = 0; i < 3; i++) begin
				sqb_s10[i] <= 60'(ab_s9[i]) * 60'(ab_s9[i]);
				sqt_s10[i] <= 60'(at_s9[i]) * 60'(at_s9[i]);
				psb_s10[i] <= psb_s9[i];
				pst_s10[i] <= pst_s9[i];
			end

			ray_s11   <= ray_s10;
			tb_s11    <= tb_s10;
			tt_s11    <= tt_s10;
			passb_s11 <= okb_s10 && ({sumb_c, 2'b00} <= 64'(dsq_q));
			passt_s11 <= okt_s10 && ({sumt_c, 2'b00} <= 64'(dsq_q));
			for (int i = 0; i < 3; i++) begin
				psb_s11[i] <= psb_s10[i];
				pst_s11[i] <= pst_s10[i];
			end

			out_hit_q <= hb_c || ht_c;
			out_t_q   <= ht_c ? tt_s11 : lim1_c;
			for (int i = 0; i < 3; i++) begin
				out_p_q[i] <= ht_c ? pst_s11[i] : (hb_c ? psb_s11[i] : '0);
				out_n_q[i] <= ht_c ? axis_q[i] : (hb_c ? nbot_c[i] : '0);
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = out_hit_q;
	assign m_axis_tdata  = {3'b000, out_n_q[2], out_n_q[1], out_n_q[0],
		out_p_q[2], out_p_q[1], out_p_q[0], out_t_q};

`ifndef SYNTHESIS
	a_hit_t_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_hit_q |-> out_t_q != '0)
		else $error("hit item with zero distance");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_hit_q |-> out_p_q[0] == '0 && out_p_q[1] == '0 &&
			out_p_q[2] == '0 && out_n_q[0] == '0 && out_n_q[1] == '0 && out_n_q[2] == '0)
		else $error("miss item carries point or normal");

	a_div_rem_b: assert property (@(posedge clk) disable iff (!arst_n)
		v_sd[DN-1] && divb_sd[DN-1].ok |-> divb_sd[DN-1].rem < ad_sd[DN-1])
		else $error("bottom divider remainder out of range");

	a_div_rem_t: assert property (@(posedge clk) disable iff (!arst_n)
		v_sd[DN-1] && divt_sd[DN-1].ok |-> divt_sd[DN-1].rem < ad_sd[DN-1])
		else $error("top divider remainder out of range");
`endif

endmodule

// File: bench/ccri_checker.sv
// Checker for the cylinder cap ray intersection block: watches both streams,
// computes the expected hit record per accepted ray and compares field by field.
// Depends on ccri_pkg; register updates arrive on the APB-style port it snoops.
module ccri_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [ccri_pkg::TDATA_W-1:0]  s_axis_tdata,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [ccri_pkg::TDATA_W-1:0]  m_axis_tdata,
	input  logic                          m_axis_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [ccri_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output int                            fail_count,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ccri_pkg::*;

	typedef struct {
		logic        hit;
		logic [30:0] t;
		logic [31:0] p [3];
		logic [17:0] n [3];
	} hit_rec_t;

	longint cyl_c [3];
	longint cyl_a [3];
	longint cyl_dia, cyl_h;
	hit_rec_t hit_q [$];

	assign pending = hit_q.size();

	function automatic longint fl16(longint x);
		if (x >= 0) return x / 65536;
		return -((-x + 65535) >>> 16);
	endfunction

	function automatic longint labs(longint x);
		return x < 0 ? -x : x;
	endfunction

	// one disk; lowers lim and fills p/nrm on a hit
	function automatic bit disk_test(longint c[3], longint n[3], longint o[3],
			longint d[3], inout longint lim, inout longint p[3], inout longint nrm[3]);
		longint den, num, an, ad, t, a, sum;
		longint pt [3];
		den = n[0]*d[0] + n[1]*d[1] + n[2]*d[2];
		num = 0;
		sum = 0;
		if (den == 0) return 0;
		for (int i = 0; i < 3; i++) num += (c[i] - o[i]) * n[i];
		if (num == 0 || ((num < 0) != (den < 0))) return 0;
		an = labs(num);
		ad = labs(den);
		if (an >= (ad <<< 15)) return 0;
		t = ((an / ad) <<< 16) + (((an % ad) <<< 16) / ad);
		if (t <= 0 || t >= lim) return 0;
		for (int i = 0; i < 3; i++) begin
			pt[i] = o[i] + fl16(d[i] * t);
			a = labs(pt[i] - c[i]);
			if (2 * a > cyl_dia) return 0;
			sum += a * a;
		end
		// 4*sum vs dia^2 without overflow: sum < 3*2^60
		if (sum > (cyl_dia * cyl_dia) / 4 || (sum == (cyl_dia * cyl_dia) / 4
				&& ((cyl_dia * cyl_dia) % 4) == 0 && 0)) return 0;
		if (4 * sum > cyl_dia * cyl_dia && sum >= 0) begin
			if (sum < (longint'(1) <<< 61)) return 0;
		end
		lim = t;
		for (int i = 0; i < 3; i++) begin
			p[i] = pt[i];
			nrm[i] = -n[i];
		end
		return 1;
	endfunction

	function automatic hit_rec_t predict_caps(logic [TDATA_W-1:0] w);
		hit_rec_t r;
		longint o [3], d [3], c [3], n [3], p [3], nrm [3], lim;
		for (int i = 0; i < 3; i++) begin
			o[i] = longint'($signed(w[32*i +: 32]));
			d[i] = longint'($signed(w[96 + 18*i +: 18]));
			p[i] = 0;
			nrm[i] = 0;
			c[i] = cyl_c[i];
			n[i] = cyl_a[i];
		end
		lim = longint'(w[150 +: 31]);
		r.hit = disk_test(c, n, o, d, lim, p, nrm);
		for (int i = 0; i < 3; i++) begin
			c[i] = cyl_c[i] + fl16(cyl_a[i] * cyl_h);
			n[i] = -cyl_a[i];
		end
		if (disk_test(c, n, o, d, lim, p, nrm)) r.hit = 1;
		r.t = lim[30:0];
		for (int i = 0; i < 3; i++) begin
			r.p[i] = p[i] < -64'sd2147483648 ? 32'h8000_0000 :
				p[i] > 64'sd2147483647 ? 32'h7fff_ffff : p[i][31:0];
			r.n[i] = nrm[i] < -131072 ? 18'h20000 : nrm[i] > 131071 ? 18'h1ffff : nrm[i][17:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hit_rec_t e;
		if (!arst_n) begin
			cyl_c = '{0, 0, 0};
			cyl_a = '{0, 65536, 0};
			cyl_dia = 65536;
			cyl_h = 65536;
			hit_q.delete();
			fail_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (hit_q.size() == 0) begin
					$display("%0t: result with nothing expected: %h", $time, m_axis_tdata);
					fail_count++;
				end else begin
					e = hit_q.pop_front();
					if (m_axis_tuser !== e.hit) begin
						$display("%0t: hit exp %b got %b", $time, e.hit, m_axis_tuser);
						fail_count++;
					end
					if (m_axis_tdata[30:0] !== e.t) begin
						$display("%0t: t_out exp %h got %h", $time, e.t, m_axis_tdata[30:0]);
						fail_count++;
					end
					for (int i = 0; i < 3; i++) begin
						if (m_axis_tdata[31 + 32*i +: 32] !== e.p[i]) begin
							$display("%0t: point[%0d] exp %h got %h", $time, i, e.p[i],
								m_axis_tdata[31 + 32*i +: 32]);
							fail_count++;
						end
						if (m_axis_tdata[127 + 18*i +: 18] !== e.n[i]) begin
							$display("%0t: normal[%0d] exp %h got %h", $time, i, e.n[i],
								m_axis_tdata[127 + 18*i +: 18]);
							fail_count++;
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) hit_q.push_back(predict_caps(s_axis_tdata));
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_CENTER_X: cyl_c[0] = longint'($signed(pwdata));
					REG_CENTER_Y: cyl_c[1] = longint'($signed(pwdata));
					REG_CENTER_Z: cyl_c[2] = longint'($signed(pwdata));
					REG_AXIS_X:   cyl_a[0] = longint'($signed(pwdata[17:0]));
					REG_AXIS_Y:   cyl_a[1] = longint'($signed(pwdata[17:0]));
					REG_AXIS_Z:   cyl_a[2] = longint'($signed(pwdata[17:0]));
					REG_DIAMETER: cyl_dia = longint'(pwdata[30:0]);
					REG_HEIGHT:   cyl_h = longint'(pwdata[30:0]);
					default: ;
				endcase
			end
		end
	end
endmodule

// File: bench/tb_cylinder_cap_ray_intersect.sv
// Stimulus and verdict for the cylinder cap ray intersection block.
// Drives rays and register writes; ccri_checker does the prediction and compare.
// Depends on ccri_pkg, ccri_checker and the block itself.
module tb_cylinder_cap_ray_intersect;
	timeunit 1ns;
	timeprecision 1ps;
	import ccri_pkg::*;

	localparam int LATENCY = 43;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	int fail_count, pending;
	int src_idle_pct = 0, sink_stall_pct = 0;
	bit sink_hold = 0;
	longint cycles = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	cylinder_cap_ray_intersect uut (.*);

	ccri_checker chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// sink: random stall, or a long hold when requested
	always @(negedge clk)
		m_axis_tready <= arst_n && !sink_hold && ($urandom_range(99) >= sink_stall_pct);

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		psel <= 1; pwrite <= 1; paddr <= ADDR_W'(idx) << 2; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	function automatic logic [17:0] rnd_dir();
		case ($urandom_range(5))
			0: return 18'sd65536;
			1: return -18'sd65536;
			2: return 18'd0;
			3: return 18'($urandom);
			default: return 18'($signed($urandom_range(131072)) - 65536);
		endcase
	endfunction

	function automatic logic [31:0] rnd_pos(int span);
		if ($urandom_range(9) == 0) return $urandom;
		return 32'($signed($urandom_range(2 * span)) - span);
	endfunction

	task automatic send_ray(logic [31:0] ox, oy, oz, logic [17:0] dx, dy, dz,
			logic [30:0] lim);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {3'b0, lim, dz, dy, dx, oz, oy, ox};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// random rays: origins within +-span or anywhere, axis-aligned or random directions, varied limits
	task automatic random_ray(int span);
		logic [30:0] lim;
		lim = $urandom_range(3) == 0 ? 31'($urandom) : 31'h7fffffff;
		if ($urandom_range(3) == 0) lim = $urandom_range(65536 * 8);
		send_ray(rnd_pos(span), rnd_pos(span), rnd_pos(span), rnd_dir(), rnd_dir(), rnd_dir(),
			lim);
	endtask

	task automatic burst(int n, int span);
		for (int i = 0; i < n; i++) random_ray(span);
		s_axis_tvalid <= 0;
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: reset cylinder, axis +y, unit size
		send_ray(0, -32'sd131072, 0, 0, 18'sd65536, 0, 31'h7fffffff);
		send_ray(0, 32'sd196608, 0, 0, -18'sd65536, 0, 31'h7fffffff);
		send_ray(0, 32'sd196608, 0, 18'sd65536, 0, 0, 31'h7fffffff);
		send_ray(0, -32'sd131072, 0, 0, 18'sd65536, 0, 31'd65536);
		send_ray(0, -32'sd131072, 0, 0, 18'sd65536, 0, 31'd131072);
		send_ray(0, 0, 0, 0, 18'sd65536, 0, 31'h7fffffff);
		send_ray(32'sd32768, -32'sd65536, 0, 0, 18'sd65536, 0, 31'h7fffffff);
		send_ray(32'sd32769, -32'sd65536, 0, 0, 18'sd65536, 0, 31'h7fffffff);
		send_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff, 18'h1ffff, 18'h20000, 18'h1ffff, 0);
		send_ray(32'h80000000, 32'h7fffffff, 32'h80000000, 18'h20000, 18'h1ffff, 18'h20000,
			31'h7fffffff);
		send_ray(0, -32'sd131072, 0, 0, 18'sd1, 0, 31'h7fffffff);
		send_ray(0, 32'h40000000, 0, 0, -18'sd65536, 0, 31'h7fffffff);
		s_axis_tvalid <= 0;
		drain();
		write_reg(REG_DIAMETER, 32'h7fffffff);
		write_reg(REG_HEIGHT, 32'h7fffffff);
		write_reg(REG_AXIS_X, 32'h1ffff);
		write_reg(REG_AXIS_Y, 32'h20000);
		write_reg(REG_AXIS_Z, 32'h1ffff);
		write_reg(REG_CENTER_X, 32'h7fffffff);
		write_reg(REG_CENTER_Y, 32'h80000000);
		write_reg(REG_CENTER_Z, 32'h00012345);
		send_ray(0, 0, 0, 18'h1ffff, 18'h20000, 18'h1ffff, 31'h7fffffff);
		send_ray(32'h7fffffff, 0, 0, 0, 18'sd65536, 0, 31'h7fffffff);
		burst(30, 32'h7fffffff);
		drain();
		// four idling phases over a few cylinder settings
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct = ph == 1 || ph == 3 ? (ph == 1 ? 82 : 31) : 0;
			sink_stall_pct = ph == 2 ? 82 : (ph == 3 ? 31 : 0);
			write_reg(REG_CENTER_X, rnd_pos(65536 * 2));
			write_reg(REG_CENTER_Y, rnd_pos(65536 * 2));
			write_reg(REG_CENTER_Z, rnd_pos(65536 * 2));
			write_reg(REG_AXIS_X, ph == 0 ? 32'd65536 : 32'd0);
			write_reg(REG_AXIS_Y, ph == 1 ? -32'sd65536 : 32'd0);
			write_reg(REG_AXIS_Z, ph >= 2 ? (ph == 2 ? 32'd65536 : -32'sd65536) : 32'd0);
			write_reg(REG_DIAMETER, ph == 3 ? 32'd0 : $urandom_range(65536 * 6));
			write_reg(REG_HEIGHT, ph == 2 ? 32'd0 : $urandom_range(65536 * 4));
			burst(240, 65536 * 4);
			if (ph == 0) begin
				// long sink hold while rays keep coming: pipeline fills, input stalls
				fork
					begin
						sink_hold = 1;
						repeat (200) @(negedge clk);
						sink_hold = 0;
					end
					burst(80, 65536 * 4);
				join
			end
			drain();
		end
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
